FILE: hw/rtl/matrix_vector_mac_colwise_unit_assert.svh
// Assertion macros shared by the matrix-vector MAC RTL.
`ifndef MATRIX_VECTOR_MAC_COLWISE_UNIT_ASSERT_SVH
`define MATRIX_VECTOR_MAC_COLWISE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Property checked at every edge outside reset.
`define MVMC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Combinational invariant sampled at every edge outside reset.
`define MVMC_INVARIANT(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`else
`define MVMC_ASSERT(lbl, clk, rst_n, prop, msg)
`define MVMC_INVARIANT(lbl, clk, rst_n, expr, msg)
`endif

`endif

FILE: hw/rtl/mvmc_pkg.sv
// Types and constants for the matrix-vector MAC unit.
package mvmc_pkg;

    localparam int ACC_W          = 48;
    localparam int ROW_W          = 6;
    localparam int NROWS_W        = 7;
    localparam int MAX_ROWS_DEF   = 64;
    localparam int SAMPLE_W_DEF   = 16;
    localparam logic [NROWS_W-1:0] NUM_ROWS_RST = 7'd64;

    // Item traveling down the cell chain.
    typedef struct packed {
        logic             valid;
        logic             acc_en;
        logic             last;
        logic [ROW_W-1:0] row;
    } mvmc_tok_t;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_WAIT,
        ST_DRAIN
    } mvmc_state_t;

endpackage

FILE: hw/rtl/mvmc_cell.sv
// One row cell: accumulates products for its row and shifts out on drain.
module mvmc_cell #(
    parameter int IDX    = 0,
    parameter int PROD_W = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mvmc_pkg::mvmc_tok_t               tok_in,
    input  logic signed [PROD_W-1:0]          prod_in,
    input  logic                              shift,
    input  logic signed [mvmc_pkg::ACC_W-1:0] acc_in,
    output mvmc_pkg::mvmc_tok_t               tok_out,
    output logic signed [PROD_W-1:0]          prod_out,
    output logic signed [mvmc_pkg::ACC_W-1:0] acc_out
);
    import mvmc_pkg::*;

    localparam int SUM_W = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 1;

    mvmc_tok_t                tok_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [SUM_W-1:0]  sum;
    logic [SUM_W-ACC_W:0]     sum_hi;
    logic                     hit;

    assign hit    = tok_in.valid && tok_in.acc_en && (tok_in.row == ROW_W'(IDX));
    assign sum    = SUM_W'(acc_reg) + SUM_W'(prod_in);
    assign sum_hi = sum[SUM_W-1:ACC_W-1];

    always_comb
    begin
        acc_next = acc_reg;
        if (shift)
        begin
            acc_next = acc_in;
        end
        else if (hit)
        begin
            if ((&sum_hi) || !(|sum_hi))
            begin
                acc_next = sum[ACC_W-1:0];
            end
            else if (sum[SUM_W-1])
            begin
                acc_next = {1'b1, {(ACC_W-1){1'b0}}};
            end
            else
            begin
                acc_next = {1'b0, {(ACC_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
            acc_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_in;
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_in;
    end

    assign tok_out  = tok_reg;
    assign prod_out = prod_reg;
    assign acc_out  = acc_reg;

endmodule

FILE: hw/rtl/matrix_vector_mac_colwise_unit.sv
// Top level: column-major matrix-vector MAC over a chain of row cells.
// Throughput: one element per cycle while busy is low; each element walks one cell per cycle.
// After the last element busy stays high while the chain flushes (ST_WAIT) and then while the
// drain shifts every accumulator out (ST_DRAIN); results come in row order from row 0, one
// per cycle, and results cannot be stalled.
// Reset clears all accumulators and sets num_rows to 64.
`include "matrix_vector_mac_colwise_unit_assert.svh"

module matrix_vector_mac_colwise_unit #(
    parameter int MAX_ROWS     = mvmc_pkg::MAX_ROWS_DEF,
    parameter int SAMPLE_WIDTH = mvmc_pkg::SAMPLE_W_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mvmc_pkg::NROWS_W-1:0]        cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [SAMPLE_WIDTH-1:0]      coef,
    input  logic signed [SAMPLE_WIDTH-1:0]      element,
    input  logic [mvmc_pkg::ROW_W-1:0]          row,
    input  logic                                last_element,
    output logic                                result_valid,
    output logic signed [mvmc_pkg::ACC_W-1:0]   sum,
    output logic [mvmc_pkg::ROW_W-1:0]          out_row,
    output logic                                last_result
);
    import mvmc_pkg::*;

    localparam int PROD_W = 2 * SAMPLE_WIDTH;
    localparam int CNT_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    mvmc_state_t          state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [NROWS_W-1:0]   num_rows_reg;
    logic [NROWS_W-1:0]   n_eff;
    logic                 accept;
    logic                 draining;

    mvmc_tok_t                entry_tok_reg;
    logic signed [PROD_W-1:0] entry_prod_reg;

    mvmc_tok_t                tok [0:MAX_ROWS];
    logic signed [PROD_W-1:0] prod [0:MAX_ROWS];
    logic signed [ACC_W-1:0]  acc [0:MAX_ROWS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= NUM_ROWS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            num_rows_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (num_rows_reg == '0)
        begin
            n_eff = NROWS_W'(1);
        end
        else if (num_rows_reg > NROWS_W'(MAX_ROWS))
        begin
            n_eff = NROWS_W'(MAX_ROWS);
        end
        else
        begin
            n_eff = num_rows_reg;
        end
    end

    assign busy   = (state_reg != ST_ACCUM);
    assign accept = start && !busy;

    // entry stage: multiply and tag the item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_tok_reg <= '0;
        end
        else
        begin
            entry_tok_reg.valid  <= accept;
            entry_tok_reg.acc_en <= (NROWS_W'(row) < n_eff);
            entry_tok_reg.last   <= last_element;
            entry_tok_reg.row    <= row;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_prod_reg <= PROD_W'(coef) * PROD_W'(element);
    end

    assign tok[0]  = entry_tok_reg;
    assign prod[0] = entry_prod_reg;

    assign draining    = (state_reg == ST_DRAIN);
    assign acc[MAX_ROWS] = '0;

    for (genvar i = 0; i < MAX_ROWS; i++)
    begin : g_cell
        mvmc_cell #(
            .IDX    (i),
            .PROD_W (PROD_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .tok_in   (tok[i]),
            .prod_in  (prod[i]),
            .shift    (draining),
            .acc_in   (acc[i+1]),
            .tok_out  (tok[i+1]),
            .prod_out (prod[i+1]),
            .acc_out  (acc[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_ACCUM:
            begin
                if (accept && last_element)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                // last item has passed every cell: all adds are in
                if (tok[MAX_ROWS].valid && tok[MAX_ROWS].last)
                begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end
            end
            ST_DRAIN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MAX_ROWS - 1))
                begin
                    state_next = ST_ACCUM;
                    cnt_next   = '0;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
                cnt_next   = '0;
            end
        endcase
    end

    // full MAX_ROWS shifts clear every cell; only the first n_eff are reported
    assign result_valid = draining && (NROWS_W'(cnt_reg) < n_eff);
    assign sum          = acc[0];
    assign out_row      = ROW_W'(cnt_reg);
    assign last_result  = result_valid && (NROWS_W'(cnt_reg) == (n_eff - 1'b1));

    `MVMC_INVARIANT(a_drain_chain_empty, clk, rst_n,
        !draining || !tok[0].valid, "item in chain during drain")
    `MVMC_ASSERT(a_first_row_zero, clk, rst_n,
        $rose(result_valid) |-> (out_row == '0), "drain does not start at row 0")
    `MVMC_ASSERT(a_rows_in_order, clk, rst_n,
        (result_valid && !last_result) |=> (result_valid && (out_row == $past(out_row) + 1'b1)),
        "result rows not consecutive")
    `MVMC_ASSERT(a_single_last, clk, rst_n,
        (result_valid && last_result) |=> !result_valid, "result after final row")

endmodule
